// ===== src/mlq_credit_scheduler_assert.svh =====
// Assertion macros shared by the scheduler modules
`ifndef MLQ_CREDIT_SCHEDULER_ASSERT_SVH
`define MLQ_CREDIT_SCHEDULER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define MCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define MCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/mcs_pkg.sv =====
// Package: sizes, commands and controller interface types of the scheduler
package mcs_pkg;
  localparam int unsigned NumLevels = 16;
  localparam int unsigned FifoDepth = 16;
  localparam int unsigned LvlW = $clog2(NumLevels);
  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam int unsigned CredW = $clog2(NumLevels + 1);
  localparam int unsigned AddrW = $clog2(NumLevels * FifoDepth);
  localparam int unsigned EntryW = 20;

  localparam logic CmdEnq = 1'b0;
  localparam logic CmdReq = 1'b1;

  typedef struct packed {
    logic enq;       // write item into its level FIFO
    logic scan;      // find the first eligible level, issue its head read
    logic reload;    // reload all credits and clear the used flag
    logic grant;     // pop the head, charge credit, present result
    logic fail;      // present an empty grant
  } ctl_cmd_t;

  typedef struct packed {
    logic found;     // registered scan found a level
    logic used;      // credit_used flag
  } ctl_sts_t;
endpackage

// ===== src/mcs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data
module mcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/mcs_ctrl.sv =====
// Controller: sequences enqueue, scan, reload, grant and fail steps
`include "mlq_credit_scheduler_assert.svh"
module mcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              cmd_i,
  input  mcs_pkg::ctl_sts_t sts_i,
  output mcs_pkg::ctl_cmd_t ctl_o,
  output logic              busy
);
  import mcs_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDec1  = 3'd2;
  localparam logic [2:0] StScan2 = 3'd3;
  localparam logic [2:0] StDec2  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (cmd_i == CmdEnq) ctl_o.enq = 1'b1;
          else begin
            ctl_o.scan = 1'b1;
            state_d = StDec1;
          end
        end
      end
      StDec1: begin
        if (sts_i.found) begin
          ctl_o.grant = 1'b1;
          state_d = StIdle;
        end else if (sts_i.used) begin
          ctl_o.reload = 1'b1;
          state_d = StScan2;
        end else begin
          ctl_o.fail = 1'b1;
          state_d = StIdle;
        end
      end
      StScan2: begin
        ctl_o.scan = 1'b1;
        state_d = StDec2;
      end
      StDec2: begin
        if (sts_i.found) ctl_o.grant = 1'b1;
        else ctl_o.fail = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign busy = (state_q != StIdle);

  `MCS_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(ctl_o))
  `MCS_ASSERT_NXT(a_reload_rescan, clk_i, rst_ni, ctl_o.reload, ctl_o.scan)
  `MCS_ASSERT_NXT(a_scan_decides, clk_i, rst_ni, ctl_o.scan,
                  ctl_o.grant || ctl_o.fail || ctl_o.reload)
endmodule

// ===== src/mcs_dpath.sv =====
// Datapath: FIFO pointers, credits, priority scan, entry memory and result register
`include "mlq_credit_scheduler_assert.svh"
module mcs_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcs_pkg::ctl_cmd_t ctl_i,
  output mcs_pkg::ctl_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [7:0]        task_id_i,
  input  logic [3:0]        level_i,
  input  logic [11:0]       work_left_i,
  output logic              done_o,
  output logic              grant_valid_o,
  output logic [7:0]        grant_id_o,
  output logic [3:0]        grant_level_o,
  output logic [4:0]        grant_slice_o,
  output logic              dropped_o
);
  import mcs_pkg::*;

  logic [15:0]      quantum_q;
  logic [PtrW-1:0]  head_q [NumLevels];
  logic [CntW-1:0]  count_q [NumLevels];
  logic [CredW-1:0] credit_q [NumLevels];
  logic             used_q;
  logic             found_q;
  logic [LvlW-1:0]  sel_q;

  // Priority scan over levels (independent per-level eligibility, then encode)
  logic            hit;
  logic [LvlW-1:0] hit_lvl;
  always_comb begin
    hit = 1'b0;
    hit_lvl = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (credit_q[i] != '0 && count_q[i] != '0) begin
        hit = 1'b1;
        hit_lvl = LvlW'(i);
      end
    end
  end

  // Enqueue check
  logic            lvl_ok, enq_ok;
  logic [LvlW-1:0] elvl;
  logic [PtrW-1:0] wpos;
  assign lvl_ok = ({1'b0, level_i} < 5'(NumLevels));
  assign elvl   = level_i[LvlW-1:0];
  assign enq_ok = lvl_ok && (count_q[elvl] < CntW'(FifoDepth));
  assign wpos   = PtrW'(head_q[elvl] + PtrW'(count_q[elvl]));

  logic [EntryW-1:0] rdata;
  mcs_ram #(.Width(EntryW), .Depth(NumLevels * FifoDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.enq && enq_ok),
    .waddr_i ({elvl, wpos}),
    .wdata_i ({task_id_i, work_left_i}),
    .raddr_i ({hit_lvl, head_q[hit_lvl]}),
    .rdata_o (rdata)
  );

  // Slice = min(work, credit, quantum)
  logic [11:0]      work;
  logic [CredW-1:0] cred, slice;
  assign work = rdata[11:0];
  assign cred = credit_q[sel_q];
  always_comb begin
    slice = cred;
    if (work < 12'(cred)) slice = CredW'(work);
    if (16'(slice) > quantum_q) slice = CredW'(quantum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= 16'd2;
      used_q    <= 1'b0;
      found_q   <= 1'b0;
      sel_q     <= '0;
      done_o    <= 1'b0;
      grant_valid_o <= 1'b0;
      grant_id_o    <= '0;
      grant_level_o <= '0;
      grant_slice_o <= '0;
      dropped_o     <= 1'b0;
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i]   <= '0;
        count_q[i]  <= '0;
        credit_q[i] <= CredW'(NumLevels - i);
      end
    end else begin
      if (cfg_we_i) quantum_q <= cfg_data_i;
      done_o <= ctl_i.enq || ctl_i.grant || ctl_i.fail;
      if (ctl_i.scan) begin
        found_q <= hit;
        sel_q   <= hit_lvl;
      end
      if (ctl_i.reload) begin
        used_q <= 1'b0;
        for (int i = 0; i < NumLevels; i++) credit_q[i] <= CredW'(NumLevels - i);
      end
      if (ctl_i.enq) begin
        grant_valid_o <= 1'b0;
        grant_id_o    <= '0;
        grant_level_o <= '0;
        grant_slice_o <= '0;
        dropped_o     <= !enq_ok;
        if (enq_ok) count_q[elvl] <= count_q[elvl] + 1'b1;
      end
      if (ctl_i.fail) begin
        grant_valid_o <= 1'b0;
        grant_id_o    <= '0;
        grant_level_o <= '0;
        grant_slice_o <= '0;
        dropped_o     <= 1'b0;
      end
      if (ctl_i.grant) begin
        head_q[sel_q]   <= PtrW'(head_q[sel_q] + 1'b1);
        count_q[sel_q]  <= count_q[sel_q] - 1'b1;
        credit_q[sel_q] <= cred - slice;
        used_q          <= 1'b1;
        grant_valid_o   <= 1'b1;
        grant_id_o      <= rdata[19:12];
        grant_level_o   <= 4'(sel_q);
        grant_slice_o   <= 5'(slice);
        dropped_o       <= 1'b0;
      end
    end
  end

  assign sts_o.found = found_q;
  assign sts_o.used  = used_q;

  `MCS_ASSERT_IMP(a_grant_nonempty, clk_i, rst_ni, ctl_i.grant, count_q[sel_q] != '0)
  `MCS_ASSERT_IMP(a_slice_le_credit, clk_i, rst_ni, ctl_i.grant, slice <= cred)
  `MCS_ASSERT_NXT(a_grant_sets_used, clk_i, rst_ni, ctl_i.grant, used_q && grant_valid_o)
endmodule

// ===== src/mlq_credit_scheduler.sv =====
// Top level: multilevel queue scheduler with per-level credit budgets
// An enqueue result (dropped) appears in the next cycle; busy stays low. A request item
// scans, then grants or fails; if the scan finds nothing and the used flag is set, it
// reloads credits and rescans. Scan result and RAM read are registered. done_o pulses for
// one cycle with each result; the receiver cannot stall it. The user must write the quantum
// register through cfg_we_i/cfg_data_i only while the block is idle; it is not enforced.
module mlq_credit_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        cmd_i,
  input  logic [7:0]  task_id_i,
  input  logic [3:0]  level_i,
  input  logic [11:0] work_left_i,
  output logic        done_o,
  output logic        grant_valid_o,
  output logic [7:0]  grant_id_o,
  output logic [3:0]  grant_level_o,
  output logic [4:0]  grant_slice_o,
  output logic        dropped_o
);
  import mcs_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  mcs_ctrl u_ctrl (
    .clk_i (clk_i), .rst_ni (rst_ni), .start (start), .cmd_i (cmd_i),
    .sts_i (sts), .ctl_o (ctl), .busy (busy)
  );

  mcs_dpath u_dpath (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl), .sts_o (sts),
    .cfg_we_i (cfg_we_i), .cfg_data_i (cfg_data_i),
    .task_id_i (task_id_i), .level_i (level_i), .work_left_i (work_left_i),
    .done_o (done_o), .grant_valid_o (grant_valid_o), .grant_id_o (grant_id_o),
    .grant_level_o (grant_level_o), .grant_slice_o (grant_slice_o),
    .dropped_o (dropped_o)
  );
endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives the scheduler and checks every grant against its own predictor
module tb_top;
  import mcs_pkg::*;

  typedef struct packed {
    logic       valid;
    logic [7:0] id;
    logic [3:0] level;
    logic [4:0] slice;
    logic       dropped;
  } grant_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [11:0] work;
  } task_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        cmd_i = CmdEnq;
  logic [7:0]  task_id_i = '0;
  logic [3:0]  level_i = '0;
  logic [11:0] work_left_i = '0;
  logic        done_o, grant_valid_o, dropped_o;
  logic [7:0]  grant_id_o;
  logic [3:0]  grant_level_o;
  logic [4:0]  grant_slice_o;

  mlq_credit_scheduler u_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_data_i, .cmd_i, .task_id_i,
    .level_i, .work_left_i, .done_o, .grant_valid_o, .grant_id_o, .grant_level_o,
    .grant_slice_o, .dropped_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  task_t          ready_q [NumLevels][FifoDepth];
  logic [PtrW-1:0] head_ptr [NumLevels];
  int unsigned    depth_cnt [NumLevels];
  logic [4:0]     credit [NumLevels];
  logic           credit_used;
  logic [15:0]    quantum;

  grant_t      grant_q[$];
  int unsigned errors = 0;
  int unsigned accept_count = 0;
  int unsigned idle_pct = 0;

  function automatic void reload_credits();
    for (int i = 0; i < NumLevels; i++) credit[i] = 5'(NumLevels - i);
  endfunction

  function automatic bit pick_task(output grant_t g);
    task_t t;
    int unsigned s;
    g = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if (credit[i] == 0 || depth_cnt[i] == 0) continue;
      t = ready_q[i][head_ptr[i]];
      head_ptr[i] = head_ptr[i] + 1'b1;
      depth_cnt[i]--;
      s = t.work;
      if (s > credit[i]) s = credit[i];
      if (s > quantum) s = quantum;
      credit[i] = credit[i] - 5'(s);
      credit_used = 1'b1;
      g.valid = 1'b1;
      g.id = t.id;
      g.level = 4'(i);
      g.slice = 5'(s);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic grant_t schedule_next(logic cmd, logic [7:0] id, logic [3:0] lvl,
                                           logic [11:0] work);
    grant_t g;
    g = '0;
    if (cmd == CmdEnq) begin
      if (depth_cnt[lvl] >= FifoDepth) begin
        g.dropped = 1'b1;
      end else begin
        ready_q[lvl][PtrW'(head_ptr[lvl] + depth_cnt[lvl])] = '{id: id, work: work};
        depth_cnt[lvl]++;
      end
    end else if (!pick_task(g) && credit_used) begin
      reload_credits();
      credit_used = 1'b0;
      void'(pick_task(g));
    end
    return g;
  endfunction

  task automatic send_item(logic cmd, logic [7:0] id, logic [3:0] lvl, logic [11:0] work);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    // hold off while busy; busy only moves at the rising edge
    while (busy) @(negedge clk_i);
    start = 1'b1;
    cmd_i = cmd;
    task_id_i = id;
    level_i = lvl;
    work_left_i = work;
    @(posedge clk_i);
    grant_q.push_back(schedule_next(cmd, id, lvl, work));
    accept_count++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Hold until every grant is back, then let the block settle
  task automatic set_quantum(logic [15:0] q);
    while (grant_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = q;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    quantum = q;
  endtask

  always @(posedge clk_i) begin
    grant_t e;
    if (rst_ni && done_o) begin
      accept_count++;
      if (grant_q.size() == 0) begin
        $error("grant with no item outstanding");
        errors++;
      end else begin
        e = grant_q.pop_front();
        if (grant_valid_o !== e.valid) begin
          $error("grant_valid: expected %0d, got %0d", e.valid, grant_valid_o); errors++;
        end
        if (grant_id_o !== e.id) begin
          $error("grant_id: expected %0d, got %0d", e.id, grant_id_o); errors++;
        end
        if (grant_level_o !== e.level) begin
          $error("grant_level: expected %0d, got %0d", e.level, grant_level_o); errors++;
        end
        if (grant_slice_o !== e.slice) begin
          $error("grant_slice: expected %0d, got %0d", e.slice, grant_slice_o); errors++;
        end
        if (dropped_o !== e.dropped) begin
          $error("dropped: expected %0d, got %0d", e.dropped, dropped_o); errors++;
        end
      end
    end
  end

  // Watchdog on stalled progress
  always @(posedge clk_i) begin
    static int unsigned last_count = 0;
    static int unsigned stall = 0;
    if (accept_count != last_count) begin
      last_count = accept_count;
      stall = 0;
    end else if (++stall >= 20000) begin
      $display("mlq_credit_scheduler: mismatch");
      $finish;
    end
  end

  task automatic test_empty_requests();
    send_item(CmdReq, 8'h00, 4'd0, 12'd0);   // nothing queued, flag clear (on the first call)
    send_item(CmdEnq, 8'hFF, 4'd15, 12'hFFF);
    send_item(CmdEnq, 8'h00, 4'd0, 12'd0);   // zero work still granted
    send_item(CmdReq, 8'h00, 4'd0, 12'd0);
    send_item(CmdReq, 8'h00, 4'd0, 12'd0);
    send_item(CmdReq, 8'h00, 4'd0, 12'd0);   // empty with flag set: reload and rescan (on the first call)
    send_item(CmdReq, 8'h00, 4'd0, 12'd0);
  endtask

  task automatic test_full_fifo();
    for (int i = 0; i <= FifoDepth; i++)
      send_item(CmdEnq, 8'(i + 100), 4'd3, 12'(i * 37));
  endtask

  task automatic test_random(int unsigned n);
    logic [3:0] lvl;
    for (int i = 0; i < n; i++) begin
      lvl = ($urandom_range(3) != 0) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      send_item(($urandom_range(99) < 55) ? CmdEnq : CmdReq, 8'($urandom_range(255)), lvl,
                ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(20)));
    end
  endtask

  initial begin
    for (int i = 0; i < NumLevels; i++) begin
      head_ptr[i] = '0;
      depth_cnt[i] = 0;
    end
    reload_credits();
    credit_used = 1'b0;
    quantum = 16'd2;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_pct = 38;
    test_empty_requests();
    test_full_fifo();
    set_quantum(16'hFFFF);
    test_empty_requests();
    test_random(160);
    set_quantum(16'd0);
    test_random(160);
    idle_pct = 76;
    set_quantum(16'd1);
    test_random(160);
    set_quantum(16'd5);
    test_random(160);
    idle_pct = 0;
    set_quantum(16'(1 << $urandom_range(15)));
    test_random(200);
    set_quantum(16'hFFFF);
    test_random(160);

    while (grant_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("mlq_credit_scheduler: match");
    end else begin
      $display("mlq_credit_scheduler: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/mcs_pkg.sv
src/mcs_ram.sv
src/mcs_ctrl.sv
src/mcs_dpath.sv
src/mlq_credit_scheduler.sv
tb/tb_top.sv
